// File: src/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Types and widths shared by the nearest-point-on-segment pipeline.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int CW   = 32;          // coordinate width, Q16.16
  localparam int DW   = CW + 1;      // difference width
  localparam int PW   = 2 * DW;      // product of two differences
  localparam int DOTW = PW + 2;      // signed dot product
  localparam int AW   = DOTW - 1;    // dot magnitude
  localparam int HW   = 34;          // low split of the dot magnitude
  localparam int L2W  = PW;          // squared length, unsigned
  localparam int NW   = DW + AW;     // numerator magnitude
  localparam int QB   = 36;          // quotient bits, one divider cell each
  localparam int RW   = L2W + 1;     // partial remainder
  localparam int SW   = QB + 2;      // projected coordinate before clipping
  localparam int THW  = 32;          // threshold register width
  localparam int IXW  = 1;           // register index width

  localparam logic [IXW-1:0] REG_LINE_MODE = IXW'(0);
  localparam logic [IXW-1:0] REG_DOT_THR   = IXW'(1);
  localparam logic [THW-1:0] DOT_THR_RST   = THW'(429497);

  typedef enum logic [1:0] {
    CASE_START = 2'd0,
    CASE_PROJ  = 2'd1,
    CASE_END   = 2'd2,
    CASE_DEGEN = 2'd3
  } rcase_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } nps_in_t;

  typedef struct packed {
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    rcase_t               result_case;
    logic                 saturated;
  } nps_out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][CW-1:0] e;
    logic [2:0]         neg;
    logic               early;
    logic               line_mode;
  } nps_side_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QB-1:0] nq;
    logic [L2W-1:0]     len2;
    nps_side_t          side;
  } nps_div_t;

endpackage

// File: src/nearest_point_on_segment_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_on_segment_top
// Nearest point on a 3D segment or line, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: query point, start and end points.
//   out_valid/out_ready return the nearest point, the case code and the
//   saturation flag, one result per request, in order.
//   cfg_we writes line_mode (index 0) or dot_threshold (index 1);
//   write only while no request is in flight.
// Pipeline: 6 front-end stages, a chain of 36 divider cells, one quotient
//   bit each, and the output register; the cell chain sets the depth.
// Throughput: one request per cycle unless out_ready stalls the pipeline.
// Reset: synchronous, active low; empties the pipeline, line_mode returns to
//   segment mode and dot_threshold to 429497.
// Stall: when out_ready is low the result holds; stages behind it keep
//   filling empty slots, so in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module nearest_point_on_segment_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nps_pkg::nps_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nps_pkg::nps_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [nps_pkg::IXW-1:0]    cfg_index,
  input  logic [nps_pkg::THW-1:0]    cfg_wdata
);
  import nps_pkg::*;

  logic            line_mode_r;
  logic [THW-1:0]  dot_thr_r;

  logic     lnk_vld [QB+1];
  logic     lnk_rdy [QB+1];
  nps_div_t lnk_dat [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= 1'b0;
      dot_thr_r   <= DOT_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_MODE: line_mode_r <= cfg_wdata[0];
        REG_DOT_THR:   dot_thr_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  nps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .line_mode     (line_mode_r),
    .dot_threshold (dot_thr_r),
    .in_vld        (in_valid),
    .in_rdy        (in_ready),
    .in_data       (in_data),
    .out_vld       (lnk_vld[0]),
    .out_rdy       (lnk_rdy[0]),
    .out_data      (lnk_dat[0])
  );

  genvar c;
  generate
    for (c = 0; c < QB; c++) begin : g_cell
      nps_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (lnk_vld[c]),
        .in_rdy   (lnk_rdy[c]),
        .in_data  (lnk_dat[c]),
        .out_vld  (lnk_vld[c+1]),
        .out_rdy  (lnk_rdy[c+1]),
        .out_data (lnk_dat[c+1])
      );
    end
  endgenerate

  nps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (lnk_vld[QB]),
    .in_rdy   (lnk_rdy[QB]),
    .in_data  (lnk_dat[QB]),
    .out_vld  (out_valid),
    .out_rdy  (out_ready),
    .out_data (out_data)
  );

endmodule

// File: src/nps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_front
// Six-stage front end: differences, dot product, squared length, the early
// decision and the numerator magnitude for the divider chain.
// ----------------------------------------------------------------------------
module nps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              line_mode,
  input  logic [31:0]       dot_threshold,
  input  logic              in_vld,
  output logic              in_rdy,
  input  nps_pkg::nps_in_t  in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output nps_pkg::nps_div_t out_data
);
  import nps_pkg::*;

  logic [6:1] v_r;
  logic [6:1] rdy;

  logic [2:0][CW-1:0] s1_r, e1_r, s2_r, e2_r, s3_r, e3_r, s4_r, e4_r, s5_r, e5_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] w1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] d3_r [3];
  logic signed [PW-1:0] dw2_r [3];
  logic [PW-1:0]        dd2_r [3];
  logic signed [DOTW-1:0] dot3_r;
  logic [L2W-1:0]       len3_r, len4_r, len5_r;
  logic [AW-1:0]        adot4_r;
  logic [DW-1:0]        ad4_r [3];
  logic [2:0]           neg4_r, neg5_r;
  logic                 early4_r, early5_r, line4_r, line5_r;
  logic [DW+HW-1:0]     pl5_r [3];
  logic [DW+AW-HW-1:0]  ph5_r [3];
  nps_div_t             o6_r;

  logic [2:0][CW-1:0] ps, ss, es;
  logic signed [DOTW-1:0] dot_nxt;
  logic [L2W-1:0]       len_nxt;
  logic                 early_nxt;
  logic [AW-1:0]        adot_nxt;
  logic [NW-1:0]        num [3];

  assign ps = {in_data.point_z, in_data.point_y, in_data.point_x};
  assign ss = {in_data.start_z, in_data.start_y, in_data.start_x};
  assign es = {in_data.end_z, in_data.end_y, in_data.end_x};

  // stage ready: empty, or the next stage moves on
  assign rdy[6] = !v_r[6] || out_rdy;
  genvar k;
  generate
    for (k = 1; k < 6; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end
  endgenerate
  assign in_rdy   = rdy[1];
  assign out_vld  = v_r[6];
  assign out_data = o6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_vld;
      for (int i = 2; i <= 6; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    dot_nxt = '0;
    len_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      dot_nxt = dot_nxt + DOTW'(dw2_r[i]);
      len_nxt = len_nxt + dd2_r[i];
    end
  end

  // numerator = low partial + high partial shifted into place
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'(pl5_r[i]) + (NW'(ph5_r[i]) << HW);
    end
  end

  assign early_nxt = (!line_mode && (dot3_r[DOTW-1] ||
                      dot3_r <= $signed({{(DOTW-THW){1'b0}}, dot_threshold}))) ||
                     (len3_r == '0);
  assign adot_nxt  = dot3_r[DOTW-1] ? AW'(-dot3_r) : AW'(dot3_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r <= ss;
      e1_r <= es;
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= $signed({es[i][CW-1], es[i]}) - $signed({ss[i][CW-1], ss[i]});
        w1_r[i] <= $signed({ps[i][CW-1], ps[i]}) - $signed({ss[i][CW-1], ss[i]});
      end
    end
    if (rdy[2]) begin
      s2_r <= s1_r;
      e2_r <= e1_r;
      for (int i = 0; i < 3; i++) begin
        d2_r[i]  <= d1_r[i];
        dw2_r[i] <= d1_r[i] * w1_r[i];
        dd2_r[i] <= PW'(d1_r[i] * d1_r[i]);
      end
    end
    if (rdy[3]) begin
      s3_r   <= s2_r;
      e3_r   <= e2_r;
      d3_r   <= d2_r;
      dot3_r <= dot_nxt;
      len3_r <= len_nxt;
    end
    if (rdy[4]) begin
      s4_r     <= s3_r;
      e4_r     <= e3_r;
      len4_r   <= len3_r;
      adot4_r  <= adot_nxt;
      early4_r <= early_nxt;
      line4_r  <= line_mode;
      for (int i = 0; i < 3; i++) begin
        ad4_r[i]  <= d3_r[i][DW-1] ? DW'(-d3_r[i]) : DW'(d3_r[i]);
        neg4_r[i] <= d3_r[i][DW-1] ^ dot3_r[DOTW-1];
      end
    end
    if (rdy[5]) begin
      s5_r     <= s4_r;
      e5_r     <= e4_r;
      len5_r   <= len4_r;
      neg5_r   <= neg4_r;
      early5_r <= early4_r;
      line5_r  <= line4_r;
      for (int i = 0; i < 3; i++) begin
        pl5_r[i] <= ad4_r[i] * adot4_r[HW-1:0];
        ph5_r[i] <= ad4_r[i] * adot4_r[AW-1:HW];
      end
    end
    if (rdy[6]) begin
      o6_r.len2           <= len5_r;
      o6_r.side.s         <= s5_r;
      o6_r.side.e         <= e5_r;
      o6_r.side.neg       <= neg5_r;
      o6_r.side.early     <= early5_r;
      o6_r.side.line_mode <= line5_r;
      for (int i = 0; i < 3; i++) begin
        o6_r.rem[i] <= RW'(num[i] >> QB);
        o6_r.nq[i]  <= num[i][QB-1:0];
      end
    end
  end

endmodule

// File: src/nps_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_div_cell
// One restoring-division cell: one quotient bit for each of three lanes.
// ----------------------------------------------------------------------------
module nps_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  nps_pkg::nps_div_t in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output nps_pkg::nps_div_t out_data
);
  import nps_pkg::*;

  logic     vld_r;
  nps_div_t dat_r;
  nps_div_t dat_nxt;
  logic [RW-1:0] r2 [3];
  logic [2:0]    ge;

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = dat_r;

  always_comb begin
    dat_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      // shift the next numerator bit into the remainder, subtract if it fits
      r2[i] = {in_data.rem[i][RW-2:0], in_data.nq[i][QB-1]};
      ge[i] = r2[i] >= {1'b0, in_data.len2};
      dat_nxt.rem[i] = ge[i] ? r2[i] - {1'b0, in_data.len2} : r2[i];
      dat_nxt.nq[i]  = {in_data.nq[i][QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
    if (in_rdy) dat_r <= dat_nxt;
  end

endmodule

// File: src/nps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_back
// Output stage: signs the quotient, adds the start point, returns the start or
// end point in their cases or saturates, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module nps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  nps_pkg::nps_div_t in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output nps_pkg::nps_out_t out_data
);
  import nps_pkg::*;

  logic     vld_r;
  nps_out_t out_r;
  nps_out_t out_nxt;

  logic signed [SW-1:0] sq [3];
  logic signed [SW-1:0] proj [3];
  logic signed [SW-1:0] sx [3];
  logic signed [SW-1:0] ex [3];
  logic [2:0]           outside, fits;
  logic [2:0][CW-1:0]   res;
  logic                 go_end;

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i]   = SW'($signed(in_data.side.s[i]));
      ex[i]   = SW'($signed(in_data.side.e[i]));
      sq[i]   = in_data.side.neg[i] ? -$signed({2'b00, in_data.nq[i]})
                                    :  $signed({2'b00, in_data.nq[i]});
      proj[i] = sx[i] + sq[i];
      outside[i] = (sx[i] < ex[i]) ? (proj[i] < sx[i] || proj[i] > ex[i])
                                   : (proj[i] < ex[i] || proj[i] > sx[i]);
      fits[i] = (proj[i][SW-1:CW-1] == '0) || (proj[i][SW-1:CW-1] == '1);
    end
    go_end = !in_data.side.line_mode && (outside != 3'b000);
    out_nxt.saturated = 1'b0;
    if (in_data.side.early) begin
      res = in_data.side.s;
      out_nxt.result_case = in_data.side.line_mode ? CASE_DEGEN : CASE_START;
    end else if (go_end) begin
      res = in_data.side.e;
      out_nxt.result_case = CASE_END;
    end else begin
      out_nxt.result_case = CASE_PROJ;
      for (int i = 0; i < 3; i++) begin
        if (fits[i]) begin
          res[i] = proj[i][CW-1:0];
        end else begin
          // clip to the most negative or most positive code
          res[i] = proj[i][SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
          out_nxt.saturated = 1'b1;
        end
      end
    end
    out_nxt.near_x = res[0];
    out_nxt.near_y = res[1];
    out_nxt.near_z = res[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
    if (in_rdy) out_r <= out_nxt;
  end

  a_sat_only_proj: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && out_r.saturated |-> out_r.result_case == CASE_PROJ)
    else $error("saturation flagged on a non-projected result");

  a_early_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_rdy && in_data.side.early && !in_data.side.line_mode
    |=> vld_r && out_r.result_case == CASE_START)
    else $error("early segment request did not return start point");

  a_late_case: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_rdy && !in_data.side.early
    |=> vld_r && (out_r.result_case == CASE_PROJ || out_r.result_case == CASE_END))
    else $error("divided request returned start or degenerate case");

endmodule
